/* hw/rtl/jsu_pkg.sv */
// Shared request types for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_out_req;

    // One decoded group of up to four bytes, byte 0 first.
    typedef struct packed {
        logic            vld;
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
        logic            last;
        logic            error;
    } t_group;

endpackage

`default_nettype wire

/* hw/rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps
`default_nettype none

// Takes a JSON string body one byte per request (end_of_string on the final
// byte) and returns decoded UTF-8 bytes, one per output request, the first of
// them the cycle after the input is taken. A byte that yields one result or
// none does not hold the input while the output is ready, so plain text then
// runs at one byte per cycle; a \u escape completing a code point of k UTF-8
// bytes holds the input while the result register drains them. A malformed
// string yields no bytes after the fault, then one request with error and last.

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_in_req i_in_req,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_out_req     o_out_req
);

    t_group group;
    logic   take;
    logic   accept;

    assign o_ready = take;
    assign accept  = i_valid && take;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_group  (group)
    );

    jsu_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_group (group),
        .o_take  (take),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_out_req)
    );

endmodule

`default_nettype wire

/* hw/rtl/jsu_decode.sv */
// Escape and surrogate decoder with UTF-8 encoder; holds the per-string state.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_in_req i_req,
    output t_group       o_group
);

    localparam logic [3:0] PH_PLAIN = 4'd0;
    localparam logic [3:0] PH_ESC   = 4'd1;
    localparam logic [3:0] PH_HEX1  = 4'd2;
    localparam logic [3:0] PH_HEX1L = 4'd5;
    localparam logic [3:0] PH_SBS   = 4'd6;
    localparam logic [3:0] PH_SU    = 4'd7;
    localparam logic [3:0] PH_HEX2  = 4'd8;
    localparam logic [3:0] PH_HEX2L = 4'd11;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_U   = 8'h75;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;
    logic        r_err, n_err;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        single;
    logic [7:0]  single_byte;
    logic        enc;
    logic [20:0] cp;
    logic [2:0]  cnt;
    logic [3:0][7:0] bytes;
    logic [7:0]  c;

    assign c = i_req.in_byte;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            hex_val = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            hex_val = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            hex_val = 4'(c - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_second    = r_second;
        n_err       = r_err;
        single      = 1'b0;
        single_byte = c;
        enc         = 1'b0;
        cp          = 21'd0;
        if (!r_err) begin
            case (r_phase)
                PH_PLAIN: begin
                    if (c == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else begin
                        single = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_PLAIN;
                    case (c)
                        8'h62: begin single = 1'b1; single_byte = 8'h08; end
                        8'h66: begin single = 1'b1; single_byte = 8'h0C; end
                        8'h6E: begin single = 1'b1; single_byte = 8'h0A; end
                        8'h72: begin single = 1'b1; single_byte = 8'h0D; end
                        8'h74: begin single = 1'b1; single_byte = 8'h09; end
                        8'h5C, 8'h22, 8'h2F: single = 1'b1;
                        CH_U: begin
                            n_phase = PH_HEX1;
                            n_first = 16'd0;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
                PH_SBS: begin
                    if (c != CH_BSL) n_err = 1'b1;
                    else n_phase = PH_SU;
                end
                PH_SU: begin
                    if (c != CH_U) begin
                        n_err = 1'b1;
                    end else begin
                        n_phase  = PH_HEX2;
                        n_second = 16'd0;
                    end
                end
                default: begin
                    if (r_phase inside {[PH_HEX1:PH_HEX1L]}) begin
                        if (!hex_ok) begin
                            n_err = 1'b1;
                        end else begin
                            n_first = {r_first[11:0], hex_val};
                            if (r_phase != PH_HEX1L) begin
                                n_phase = r_phase + 4'd1;
                            end else if (n_first inside {[16'hD800:16'hDBFF]}) begin
                                n_phase = PH_SBS;
                            end else begin
                                n_phase = PH_PLAIN;
                                if (n_first inside {[16'hDC00:16'hDFFF]}) begin
                                    n_err = 1'b1;
                                end else begin
                                    enc = 1'b1;
                                    cp  = {5'd0, n_first};
                                end
                            end
                        end
                    end else if (r_phase inside {[PH_HEX2:PH_HEX2L]}) begin
                        if (!hex_ok) begin
                            n_err = 1'b1;
                        end else begin
                            n_second = {r_second[11:0], hex_val};
                            if (r_phase != PH_HEX2L) begin
                                n_phase = r_phase + 4'd1;
                            end else begin
                                n_phase = PH_PLAIN;
                                if (!(n_second inside {[16'hDC00:16'hDFFF]})) begin
                                    n_err = 1'b1;
                                end else begin
                                    enc = 1'b1;
                                    cp  = 21'h10000 + {1'b0, r_first[9:0], n_second[9:0]};
                                end
                            end
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
            endcase
        end
    end

    // UTF-8 encoding of the completed code point
    always_comb begin
        bytes = '0;
        cnt   = 3'd0;
        if (single) begin
            bytes[0] = single_byte;
            cnt      = 3'd1;
        end else if (enc) begin
            if (cp <= 21'h7F) begin
                bytes[0] = cp[7:0];
                cnt      = 3'd1;
            end else if (cp <= 21'h7FF) begin
                bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
                bytes[1] = 8'h80 | {2'd0, cp[5:0]};
                cnt      = 3'd2;
            end else if (cp <= 21'hFFFF) begin
                bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
                bytes[1] = 8'h80 | {2'd0, cp[11:6]};
                bytes[2] = 8'h80 | {2'd0, cp[5:0]};
                cnt      = 3'd3;
            end else begin
                bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
                bytes[1] = 8'h80 | {2'd0, cp[17:12]};
                bytes[2] = 8'h80 | {2'd0, cp[11:6]};
                bytes[3] = 8'h80 | {2'd0, cp[5:0]};
                cnt      = 3'd4;
            end
        end
        if (n_err) cnt = 3'd0;
    end

    logic fin_err;
    assign fin_err = n_err || (n_phase != PH_PLAIN) || (cnt == 3'd0);

    always_comb begin
        o_group       = '0;
        o_group.bytes = bytes;
        o_group.cnt   = cnt;
        if (i_req.end_of_string) begin
            o_group.last = 1'b1;
            if (fin_err) begin
                o_group.bytes = '0;
                o_group.cnt   = 3'd1;
                o_group.error = 1'b1;
            end
        end
        o_group.vld = i_accept && (o_group.cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PLAIN;
            r_first  <= 16'd0;
            r_second <= 16'd0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            if (i_req.end_of_string) begin
                r_phase  <= PH_PLAIN;
                r_first  <= 16'd0;
                r_second <= 16'd0;
                r_err    <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_first  <= n_first;
                r_second <= n_second;
                r_err    <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/jsu_drain.sv */
// Result register: holds one decoded group; hands out a byte per cycle while i_ready.
`timescale 1ns / 1ps
`default_nettype none

module jsu_drain
    import jsu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_group i_group,
    output logic        o_take,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out_req    o_req
);

    logic [2:0]      r_left;
    logic [3:0][7:0] r_bytes;
    logic            r_last;
    logic            r_err;
    logic            pop;

    assign o_valid = (r_left != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_take  = (r_left == 3'd0) || ((r_left == 3'd1) && i_ready);

    assign o_req.out_byte = r_bytes[0];
    assign o_req.last     = r_last && (r_left == 3'd1);
    assign o_req.error    = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_group.vld && o_take) begin
            r_left <= i_group.cnt;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_group.vld && o_take) begin
            r_bytes <= i_group.bytes;
            r_last  <= i_group.last;
            r_err   <= i_group.error;
        end else if (pop) begin
            r_bytes <= {8'd0, r_bytes[3:1]};
        end
    end

    a_err_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_req.error |-> o_req.last && (o_req.out_byte == 8'd0))
        else $error("error result without last or with nonzero byte");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_group.vld && o_take |=> o_valid)
        else $error("loaded group not presented");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'd4)
        else $error("byte count out of range");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |-> o_valid && (r_left != 3'd1 || !i_ready))
        else $error("input stalled with nothing to drain");

endmodule

`default_nettype wire
